// ===== rtl/lrss_pkg.sv =====
// Shared types and codes for the record stack with key search.
// Used by lrss_cell, lrss_chain and lifo_record_stack_with_search_top.
package lrss_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int WORD_W        = 64;
   localparam int WORDS         = 3;

   typedef logic [WORDS-1:0][WORD_W-1:0] words_type;

   typedef struct packed {
      words_type name;
      words_type key;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_DISPLAY = 3'd3,
      CMD_SEARCH  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_DONE      = 3'd0,
      STAT_VALID     = 3'd1,
      STAT_EMPTY     = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CH_HOLD,
      CH_PUSH,
      CH_POP,
      CH_ROT
   } chain_op_type;

   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_ABOVE,
      SEL_BELOW,
      SEL_WRAP
   } cell_sel_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

// ===== rtl/lrss_cell.sv =====
// One stack slot: a record register with its neighbor select.
// Depends on lrss_pkg.
module lrss_cell
   import lrss_pkg::*;
(
   input  logic         clock,
   input  cell_sel_type sel,
   input  entry_type    above,
   input  entry_type    below,
   input  entry_type    wrap,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      case (sel)
         SEL_ABOVE: entry_in = above;
         SEL_BELOW: entry_in = below;
         SEL_WRAP:  entry_in = wrap;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/lrss_chain.sv =====
// Row of stack cells, top of stack in cell 0; push shifts down, pop shifts up,
// rotate moves the occupied cells up by one and wraps the top to the bottom.
// Depends on lrss_pkg and lrss_cell.
module lrss_chain
   import lrss_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  chain_op_type  op,
   input  logic [CW-1:0] count,
   input  entry_type     push_entry,
   output entry_type     top_entry
);

   entry_type    cell_q [DEPTH];
   cell_sel_type sel [DEPTH];
   logic [CW-1:0] last_idx;

   assign last_idx  = count - CW'(1);
   assign top_entry = cell_q[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type above;
      entry_type below;

      if (i == 0) begin : g_first
         assign above = push_entry;
      end else begin : g_mid
         assign above = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign below = cell_q[i];
      end else begin : g_inner
         assign below = cell_q[i+1];
      end

      always_comb begin
         case (op)
            CH_PUSH: sel[i] = SEL_ABOVE;
            CH_POP:  sel[i] = (i < DEPTH - 1) ? SEL_BELOW : SEL_HOLD;
            CH_ROT: begin
               if (CW'(i) == last_idx) begin
                  sel[i] = SEL_WRAP;
               end else if (CW'(i) < count) begin
                  sel[i] = SEL_BELOW;
               end else begin
                  sel[i] = SEL_HOLD;
               end
            end
            default: sel[i] = SEL_HOLD;
         endcase
      end

      lrss_cell u_cell (
         .clock (clock),
         .sel   (sel[i]),
         .above (above),
         .below (below),
         .wrap  (cell_q[0]),
         .entry (cell_q[i])
      );
   end

endmodule

// ===== rtl/lifo_record_stack_with_search_top.sv =====
// Record stack with key search: command sequencer, result register, cell row.
// Depends on lrss_pkg and lrss_chain.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_tvalid/tready    | tuser cmd, tdata key and name words
//   rsp_    | out       | rsp_tvalid/tready    | tuser status, tdata entry, tlast
//
// Push, pop, peek and an empty-stack reply are handled in the idle state, one reply each.
// Display and search (count = entries held, up to DEPTH) accept the item,
// then take one walk step per entry. Each step rotates the
// cell row by one entry past cell 0, which feeds the result register and the
// 192-bit key compare. The row ends in its original order.
// A walk step advances only when the result register is free or being taken.
// Reset (synchronous) empties the stack; cell contents are not cleared.
module lifo_record_stack_with_search_top
   import lrss_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // cmd
   input  logic [383:0] req_tdata,   // key_word0..2, name_word0..2
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic [383:0] rsp_tdata,   // out_key0..2, out_name0..2
   output logic         rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;
   logic          found_ff, found_in;
   cmd_type       cmd_ff, cmd_in;
   words_type     key_ff, key_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic          rsp_last_ff, rsp_last_in;

   chain_op_type  chain_op;
   entry_type     push_entry;
   entry_type     top_entry;
   logic          can_load;
   logic          last_step;
   logic          key_match;

   assign push_entry = entry_type'(req_tdata);
   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign last_step  = (step_ff == count_ff - CW'(1));
   assign key_match  = (top_entry.key == key_ff);

   lrss_chain #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_chain (
      .clock      (clock),
      .op         (chain_op),
      .count      (count_ff),
      .push_entry (push_entry),
      .top_entry  (top_entry)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      chain_op      = CH_HOLD;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = can_load;
            if (req_tvalid && can_load) begin
               rsp_entry_in = '0;
               rsp_last_in  = 1'b1;
               case (req_tuser)
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        chain_op      = CH_PUSH;
                        count_in      = count_ff + CW'(1);
                        rsp_status_in = STAT_DONE;
                     end
                  end
                  CMD_POP: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        chain_op      = CH_POP;
                        count_in      = count_ff - CW'(1);
                        rsp_status_in = STAT_DONE;
                     end
                  end
                  CMD_PEEK: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_status_in = STAT_VALID;
                        rsp_entry_in  = top_entry;
                     end
                  end
                  CMD_DISPLAY, CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_WALK;
                        step_in  = '0;
                        found_in = 1'b0;
                        cmd_in   = cmd_type'(req_tuser);
                        key_in   = push_entry.key;
                     end
                  end
                  default: begin
                     // unknown command: drop the item
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (can_load) begin
               chain_op = CH_ROT;
               step_in  = step_ff + CW'(1);
               if (cmd_ff == CMD_DISPLAY) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_VALID;
                  rsp_entry_in  = top_entry;
                  rsp_last_in   = last_step;
               end else if (!found_ff && key_match) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_VALID;
                  rsp_entry_in  = top_entry;
                  rsp_last_in   = 1'b1;
                  found_in      = 1'b1;
               end else if (!found_ff && last_step) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NOT_FOUND;
                  rsp_entry_in  = '0;
                  rsp_last_in   = 1'b1;
               end
               // keep rotating after a hit so the stack order is restored
               if (last_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      found_ff      <= found_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_entry_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> count_ff != '0)
      else $error("walk on an empty stack");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_VALID |-> rsp_tdata == '0)
      else $error("entry data on a status-only item");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_PUSH && count_ff != CW'(DEPTH)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the stack");
`endif

endmodule

// ===== dv/tb_lifo_record_stack_with_search_top.sv =====
// Self-checking testbench for lifo_record_stack_with_search_top: directed and random
// push, pop, peek, display and search items, checked against an in-bench stack model.
// Depends on lrss_pkg and the RTL of the record stack.
module tb_lifo_record_stack_with_search_top
   import lrss_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH    = DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 2 * STACK_DEPTH + 8;

   typedef struct packed {
      status_type status;
      words_type  key;
      words_type  name;
      logic       last;
   } stack_reply_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [2:0]   req_tuser;   // cmd
   logic [383:0] req_tdata;   // key_word0..2, name_word0..2
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [2:0]   rsp_tuser;   // status
   logic [383:0] rsp_tdata;   // out_key0..2, out_name0..2
   logic         rsp_tlast;

   // stack model
   words_type       held_key [STACK_DEPTH];
   words_type       held_name[STACK_DEPTH];
   int              held_count = 0;
   stack_reply_type expected_replies[$];

   int           errors = 0;
   int           quiet_cycles = 0;
   bit           req_gaps_on = 1'b0;
   bit           rsp_stalls_on = 1'b0;

   lifo_record_stack_with_search_top #(
      .DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void add_reply(status_type st, int entry, logic is_last);
      stack_reply_type r;
      r.status = st;
      r.key    = (entry >= 0) ? held_key[entry] : '0;
      r.name   = (entry >= 0) ? held_name[entry] : '0;
      r.last   = is_last;
      expected_replies.push_back(r);
   endfunction

   // Update the stack model for one accepted item and queue the replies it causes.
   function automatic void apply_stack_cmd(logic [2:0] code, words_type key, words_type name);
      int i;
      bit found;
      if (code > CMD_SEARCH) return;
      if (code == CMD_PUSH) begin
         if (held_count >= STACK_DEPTH) begin
            add_reply(STAT_FULL, -1, 1'b1);
         end else begin
            held_key[held_count]  = key;
            held_name[held_count] = name;
            held_count++;
            add_reply(STAT_DONE, -1, 1'b1);
         end
         return;
      end
      if (held_count == 0) begin
         add_reply(STAT_EMPTY, -1, 1'b1);
         return;
      end
      case (cmd_type'(code))
         CMD_POP: begin
            held_count--;
            add_reply(STAT_DONE, -1, 1'b1);
         end
         CMD_PEEK: begin
            add_reply(STAT_VALID, held_count - 1, 1'b1);
         end
         CMD_DISPLAY: begin
            for (i = held_count - 1; i >= 0; i--) add_reply(STAT_VALID, i, i == 0);
         end
         default: begin
            found = 1'b0;
            for (i = held_count - 1; i >= 0 && !found; i--) begin
               if (held_key[i] == key) begin
                  add_reply(STAT_VALID, i, 1'b1);
                  found = 1'b1;
               end
            end
            if (!found) add_reply(STAT_NOT_FOUND, -1, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(string fname, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %h, got %h", fname, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      stack_reply_type want;
      int j;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_stack_cmd(req_tuser, req_tdata[191:0], req_tdata[383:192]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $error("reply with nothing pending: status %0d", rsp_tuser);
               errors++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_tuser));
               for (j = 0; j < WORDS; j++) begin
                  check_field($sformatf("out_key%0d", j), want.key[j], rsp_tdata[64*j +: 64]);
                  check_field($sformatf("out_name%0d", j), want.name[j],
                              rsp_tdata[192 + 64*j +: 64]);
               end
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stall the reply side in random bursts.
   always begin
      @(negedge clock);
      if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      rsp_tready = 1'b1;
   end

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic words_type rand_words();
      words_type w;
      int j;
      for (j = 0; j < WORDS; j++) w[j] = rand_word();
      return w;
   endfunction

   // Reuse a stored key now and then so duplicates sit in the stack.
   function automatic words_type push_key();
      if (held_count > 0 && $urandom_range(0, 4) == 0)
         return held_key[$urandom_range(0, held_count - 1)];
      return rand_words();
   endfunction

   // Mostly stored keys, some with one bit flipped, the rest random.
   function automatic words_type search_key();
      words_type w;
      int wsel;
      int bsel;
      if (held_count > 0 && $urandom_range(0, 9) < 6) begin
         w = held_key[$urandom_range(0, held_count - 1)];
         if ($urandom_range(0, 2) == 0) begin
            wsel = $urandom_range(0, WORDS - 1);
            bsel = $urandom_range(0, 63);
            w[wsel][bsel] = ~w[wsel][bsel];
         end
         return w;
      end
      return rand_words();
   endfunction

   // Drive one item from a falling edge and hold it until accepted.
   task automatic issue_cmd(logic [2:0] code, words_type key, words_type name);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tuser  = code;
      req_tdata  = {name, key};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic test_empty_stack();
      issue_cmd(CMD_POP, rand_words(), rand_words());
      issue_cmd(CMD_PEEK, rand_words(), rand_words());
      issue_cmd(CMD_DISPLAY, rand_words(), rand_words());
      issue_cmd(CMD_SEARCH, rand_words(), rand_words());
   endtask

   task automatic test_unknown_codes();
      int c;
      issue_cmd(CMD_PUSH, rand_words(), rand_words());
      for (c = CMD_SEARCH + 1; c < 8; c++) issue_cmd(3'(c), rand_words(), rand_words());
      issue_cmd(CMD_PEEK, '0, '0);
      issue_cmd(CMD_POP, '0, '0);
   endtask

   task automatic test_field_extremes();
      words_type w2_only;
      w2_only    = '0;
      w2_only[2] = 64'd1;
      issue_cmd(CMD_PUSH, '0, '1);
      issue_cmd(CMD_PUSH, '1, '0);
      issue_cmd(CMD_PUSH, '0, '0);
      issue_cmd(CMD_PEEK, '1, '1);
      issue_cmd(CMD_DISPLAY, '0, '0);
      issue_cmd(CMD_SEARCH, '1, '1);
      issue_cmd(CMD_SEARCH, '0, '1);
      issue_cmd(CMD_SEARCH, w2_only, '0);
      issue_cmd(CMD_POP, '1, '1);
      issue_cmd(CMD_PEEK, '0, '0);
      issue_cmd(CMD_POP, '0, '0);
      issue_cmd(CMD_POP, '0, '0);
   endtask

   task automatic test_duplicate_keys();
      words_type k;
      k = rand_words();
      issue_cmd(CMD_PUSH, k, rand_words());
      issue_cmd(CMD_PUSH, rand_words(), rand_words());
      issue_cmd(CMD_PUSH, k, rand_words());
      issue_cmd(CMD_SEARCH, k, '0);
      while (held_count > 0) issue_cmd(CMD_POP, '0, '0);
   endtask

   task automatic test_full_stack();
      while (held_count < STACK_DEPTH) issue_cmd(CMD_PUSH, push_key(), rand_words());
      issue_cmd(CMD_PUSH, rand_words(), rand_words());
      issue_cmd(CMD_PUSH, '1, '1);
      issue_cmd(CMD_DISPLAY, '0, '0);
      issue_cmd(CMD_SEARCH, held_key[0], '0);
      issue_cmd(CMD_SEARCH, search_key(), '0);
      issue_cmd(CMD_PEEK, '0, '0);
      while (held_count > 0) issue_cmd(CMD_POP, rand_words(), rand_words());
      issue_cmd(CMD_POP, '0, '0);
      issue_cmd(CMD_DISPLAY, '0, '0);
   endtask

   task automatic test_random_mix(int count, bit with_idle);
      int sent;
      int pick;
      req_gaps_on   = with_idle;
      rsp_stalls_on = with_idle;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            issue_cmd(3'(CMD_SEARCH + $urandom_range(1, 3)), rand_words(), rand_words());
         end else begin
            sent++;
            if (pick < 44)      issue_cmd(CMD_PUSH, push_key(), rand_words());
            else if (pick < 66) issue_cmd(CMD_POP, rand_words(), rand_words());
            else if (pick < 74) issue_cmd(CMD_PEEK, rand_words(), rand_words());
            else if (pick < 82) issue_cmd(CMD_DISPLAY, rand_words(), rand_words());
            else                issue_cmd(CMD_SEARCH, search_key(), rand_words());
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_PUSH;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rsp_stalls_on = 1'b1;
      test_empty_stack();
      test_unknown_codes();
      test_field_extremes();
      test_duplicate_keys();

      test_random_mix(200, 1'b1);
      test_full_stack();
      test_random_mix(130, 1'b0);

      req_tvalid = 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
